### rtl/core/pulse_return_conflict_counter_top_defines.svh
// Assertion macros shared by the core.
`ifndef PULSE_RETURN_CONFLICT_COUNTER_TOP_DEFINES_SVH
`define PULSE_RETURN_CONFLICT_COUNTER_TOP_DEFINES_SVH

// Plain property, checked on every clock edge outside reset.
`define PRCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define PRCC_NEXT(label, ante, cons, msg) \
  `PRCC_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/core/prcc_pkg.sv
package prcc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned RetW   = 4;
  localparam int unsigned CountW = 9;

  localparam logic [CountW-1:0] CountMax = 9'd511;

  typedef struct packed {
    logic            clear_first;
    logic [KeyW-1:0] pulse_time;
    logic [RetW-1:0] return_index;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] conflict_total;
    logic              repeat_seen;
    logic              table_full;
  } res_t;

  typedef struct packed {
    logic            vld;
    logic            clear;
    logic            done;
    logic            repeat_seen;
    logic            inc;
    logic [KeyW-1:0] key;
    logic [RetW-1:0] rn;
  } tok_t;

endpackage

### rtl/core/prcc_cell.sv
`include "pulse_return_conflict_counter_top_defines.svh"

module prcc_cell #(
  parameter int RETURN_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  prcc_pkg::tok_t tok_i,
  output prcc_pkg::tok_t tok_o
);

  logic                         valid_q, valid_d;
  logic [prcc_pkg::KeyW-1:0]    key_q, key_d;
  logic [RETURN_BITS-1:0]       mask_q, mask_d;
  logic                         conflict_q, conflict_d;
  prcc_pkg::tok_t               tok_q, tok_d;

  logic                         has_bit;
  logic [RETURN_BITS-1:0]       bit_vec;
  logic                         live;
  logic                         hit;
  logic                         seen;

  always_comb begin
    has_bit = 32'(tok_i.rn) < 32'(RETURN_BITS);
    bit_vec = has_bit ? (RETURN_BITS'(1) << tok_i.rn) : '0;
    live    = valid_q && !(tok_i.vld && tok_i.clear);
    hit     = live && (key_q == tok_i.key);
    seen    = |(mask_q & bit_vec);

    valid_d    = valid_q;
    key_d      = key_q;
    mask_d     = mask_q;
    conflict_d = conflict_q;
    tok_d      = tok_i;

    if (tok_i.vld && tok_i.clear) begin
      valid_d = 1'b0;
    end

    if (tok_i.vld && !tok_i.done) begin
      if (!live) begin
        valid_d    = 1'b1;
        key_d      = tok_i.key;
        mask_d     = bit_vec;
        conflict_d = 1'b0;
        tok_d.done = 1'b1;
      end else if (hit) begin
        tok_d.done = 1'b1;
        if (seen) begin
          tok_d.repeat_seen = 1'b1;
          if (!conflict_q) begin
            conflict_d = 1'b1;
            tok_d.inc  = 1'b1;
          end
        end else begin
          mask_d = mask_q | bit_vec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    mask_q     <= mask_d;
    conflict_q <= conflict_d;
  end

  assign tok_o = tok_q;

  `PRCC_NEXT(a_claim_open, !valid_q && tok_i.vld && !tok_i.done, valid_q && tok_o.done, "empty cell not claimed")
  `PRCC_NEXT(a_done_hold, tok_i.vld && tok_i.done, tok_o.vld && tok_o.done, "settled transaction reopened")
  `PRCC_NEXT(a_conflict_mark, tok_i.vld && !tok_i.done && hit && seen && !conflict_q, conflict_q && tok_o.inc, "first repeat not marked")

endmodule

### rtl/core/prcc_tally.sv
`include "pulse_return_conflict_counter_top_defines.svh"

module prcc_tally (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  prcc_pkg::tok_t tok_i,
  output logic           res_valid_o,
  output prcc_pkg::res_t res_o
);

  logic [prcc_pkg::CountW-1:0] count_q, count_d;
  logic [prcc_pkg::CountW-1:0] base;
  logic [prcc_pkg::CountW-1:0] next_count;
  logic                        res_valid_q;
  prcc_pkg::res_t              res_q, res_d;

  always_comb begin
    base       = tok_i.clear ? '0 : count_q;
    next_count = (tok_i.inc && (base != prcc_pkg::CountMax)) ? base + 9'd1 : base;
    count_d    = tok_i.vld ? next_count : count_q;

    res_d.conflict_total = next_count;
    res_d.repeat_seen    = tok_i.repeat_seen;
    res_d.table_full     = !tok_i.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `PRCC_ASSERT(a_strobe, res_valid_o == $past(tok_i.vld), "result strobe lost or invented")
  `PRCC_NEXT(a_count_step, tok_i.vld && !tok_i.clear, count_q == $past(count_q) || count_q == $past(count_q) + 9'd1, "count moved by more than one")
  `PRCC_ASSERT(a_full_excl, !(res_valid_o && res_o.table_full && res_o.repeat_seen), "dropped transaction reported a repeat")

endmodule

### rtl/core/pulse_return_conflict_counter_top.sv
// Counts pulses whose return numbers repeat. A transaction is taken on every
// cycle with start high (busy stays low). Its result is on res_valid_o/res_o
// for one cycle only, after passing every cell and the tally register,
// and is taken at the edge that ends that cycle. Results come in order
// and the receiver cannot stall them. Keys are held in a row of TABLE_DEPTH
// cells, and each transaction passes one cell per clock. One transaction
// enters per cycle, and the length of that row sets the latency. A
// transaction with clear_first set empties the table and the count as it
// travels, ahead of its own lookup. Once TABLE_DEPTH distinct keys are held,
// a new key is dropped and reported with table_full.
module pulse_return_conflict_counter_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int RETURN_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  prcc_pkg::req_t req_i,
  output logic           res_valid_o,
  output prcc_pkg::res_t res_o
);

  prcc_pkg::tok_t chain [TABLE_DEPTH+1];
  prcc_pkg::tok_t head_tok;

  assign busy = 1'b0;

  always_comb begin
    head_tok       = '0;
    head_tok.vld   = start && !busy;
    head_tok.clear = req_i.clear_first;
    head_tok.key   = req_i.pulse_time;
    head_tok.rn    = req_i.return_index;
  end

  assign chain[0] = head_tok;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    prcc_cell #(
      .RETURN_BITS(RETURN_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  prcc_tally u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_i      (chain[TABLE_DEPTH]),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

### tb/pulse_return_conflict_counter_top_tb.sv
module pulse_return_conflict_counter_top_tb;

  localparam int unsigned KeyW   = prcc_pkg::KeyW;
  localparam int unsigned RetW   = prcc_pkg::RetW;
  localparam int unsigned CountW = prcc_pkg::CountW;
  localparam logic [CountW-1:0] CountMax = prcc_pkg::CountMax;

  typedef prcc_pkg::req_t req_t;
  typedef prcc_pkg::res_t res_t;

  localparam int TblDepth    = 256;
  localparam int ReturnBits  = 16;
  localparam int RandomItems = 1100;
  localparam int CycleLimit  = 400000;
  localparam int NumRows     = 21;

  typedef struct packed {
    logic            clear;
    logic [KeyW-1:0] key;
    logic [RetW-1:0] rn;
    logic            typed;
    logic [CountW-1:0] total;
    logic            rep;
    logic            full;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  bit              slot_used    [TblDepth];
  logic [KeyW-1:0] slot_key     [TblDepth];
  logic [15:0]     slot_mask    [TblDepth];
  bit              slot_flagged [TblDepth];
  int              flagged_keys;
  int              keys_held;

  res_t      expected_results [$];
  res_t      pending_want;
  stim_row_t directed_rows [NumRows];
  int        items_sent;
  int        burst_left;
  int        mismatch_count;
  int        cycle_count;

  pulse_return_conflict_counter_top #(
    .TABLE_DEPTH(TblDepth),
    .RETURN_BITS(ReturnBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t predict_conflicts(req_t r);
    logic [63:0] x;
    int          slot;
    bit          found;
    bit          empty;
    bit          has_bit;
    logic [15:0] bit_m;
    res_t        o;
    if (r.clear_first) begin
      slot_used    = '{default: 1'b0};
      slot_flagged = '{default: 1'b0};
      flagged_keys = 0;
      keys_held    = 0;
    end
    has_bit = int'(r.return_index) < ReturnBits;
    bit_m   = has_bit ? (16'd1 << r.return_index) : 16'd0;
    x = r.pulse_time ^ (r.pulse_time >> 29);
    x = x * 64'h9E37_79B9_7F4A_7C15;
    x = x ^ (x >> 32);
    slot  = int'(x % 64'(TblDepth));
    found = 1'b0;
    empty = 1'b0;
    for (int p = 0; p < TblDepth; p++) begin
      if (!slot_used[slot]) begin
        empty = 1'b1;
        break;
      end
      if (slot_key[slot] == r.pulse_time) begin
        found = 1'b1;
        break;
      end
      slot = (slot + 1) % TblDepth;
    end
    o = '0;
    if (found) begin
      if (has_bit && (slot_mask[slot] & bit_m) != 16'd0) begin
        o.repeat_seen = 1'b1;
        if (!slot_flagged[slot]) begin
          slot_flagged[slot] = 1'b1;
          if (flagged_keys < int'(CountMax)) flagged_keys++;
        end
      end else begin
        slot_mask[slot] |= bit_m;
      end
    end else if (empty && keys_held < TblDepth) begin
      slot_used[slot]    = 1'b1;
      slot_key[slot]     = r.pulse_time;
      slot_mask[slot]    = bit_m;
      slot_flagged[slot] = 1'b0;
      keys_held++;
    end else begin
      o.table_full = 1'b1;
    end
    o.conflict_total = CountW'(flagged_keys);
    return o;
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [RetW-1:0] rand_rn();
    return $urandom_range(0, 1) ? RetW'($urandom_range(0, 3)) : RetW'($urandom_range(0, 15));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic send_txn(input req_t r, input bit typed, input res_t want);
    res_t pred;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = predict_conflicts(r);
    expected_results.push_back(typed ? want : pred);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
  endtask

  task automatic run_small_set();
    logic [KeyW-1:0] pool [12];
    int              pool_n;
    int              len;
    req_t            r;
    pool_n = $urandom_range(1, 12);
    for (int i = 0; i < pool_n; i++) pool[i] = rand_key();
    len = $urandom_range(4, 40);
    for (int i = 0; i < len; i++) begin
      r.clear_first  = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 32) == 0);
      r.pulse_time   = ($urandom_range(0, 9) == 0) ? rand_key()
                                                   : pool[$urandom_range(0, pool_n - 1)];
      r.return_index = rand_rn();
      send_txn(r, 1'b0, '0);
    end
  endtask

  task automatic run_full_set();
    logic [KeyW-1:0] fill_keys [TblDepth];
    logic [RetW-1:0] fill_rn   [TblDepth];
    req_t            r;
    for (int i = 0; i < TblDepth; i++) begin
      fill_keys[i] = {$urandom, $urandom};
      fill_rn[i]   = RetW'($urandom_range(0, 15));
    end
    for (int i = 0; i < TblDepth; i++) begin
      r = '{(i == 0), fill_keys[i], fill_rn[i]};
      send_txn(r, 1'b0, '0);
    end
    repeat (3) begin
      r = '{1'b0, {$urandom, $urandom}, rand_rn()};
      send_txn(r, 1'b0, '0);
    end
    for (int i = 0; i < TblDepth; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = '{1'b0, fill_keys[i], rand_rn()};
        send_txn(r, 1'b0, '0);
      end
      r = '{1'b0, fill_keys[i], fill_rn[i]};
      send_txn(r, 1'b0, '0);
    end
    repeat (3) begin
      r = '{1'b0, {$urandom, $urandom}, rand_rn()};
      send_txn(r, 1'b0, '0);
    end
    r = '{1'b0, fill_keys[0], fill_rn[0]};
    send_txn(r, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, conflict_total", res_o.conflict_total, 0);
      end else begin
        pending_want = expected_results.pop_front();
        if (res_o.conflict_total !== pending_want.conflict_total)
          report_mismatch("conflict_total", res_o.conflict_total, pending_want.conflict_total);
        if (res_o.repeat_seen !== pending_want.repeat_seen)
          report_mismatch("repeat_seen", res_o.repeat_seen, pending_want.repeat_seen);
        if (res_o.table_full !== pending_want.table_full)
          report_mismatch("table_full", res_o.table_full, pending_want.table_full);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL pulse_return_conflict_counter_top");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    req_t      r;
    res_t      w;
    bit        full_done;
    slot_used      = '{default: 1'b0};
    slot_flagged   = '{default: 1'b0};
    flagged_keys   = 0;
    keys_held      = 0;
    items_sent     = 0;
    burst_left     = $urandom_range(1, 40);
    mismatch_count = 0;
    cycle_count    = 0;
    full_done      = 1'b0;
    directed_rows = '{
      '{1'b1, 64'h0,                   4'd0,  1'b1, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'h0,                   4'd0,  1'b1, 9'd1, 1'b1, 1'b0},
      '{1'b0, 64'h0,                   4'd0,  1'b1, 9'd1, 1'b1, 1'b0},
      '{1'b0, 64'h0,                   4'd15, 1'b1, 9'd1, 1'b0, 1'b0},
      '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 9'd1, 1'b0, 1'b0},
      '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 9'd2, 1'b1, 1'b0},
      '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 9'd2, 1'b0, 1'b0},
      '{1'b0, 64'h8000_0000_0000_0000, 4'd7,  1'b1, 9'd2, 1'b0, 1'b0},
      '{1'b0, 64'h0000_0000_0000_0001, 4'd7,  1'b1, 9'd2, 1'b0, 1'b0},
      '{1'b0, 64'h8000_0000_0000_0000, 4'd7,  1'b1, 9'd3, 1'b1, 1'b0},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 9'd1, 1'b1, 1'b0},
      '{1'b0, 64'h0,                   4'd3,  1'b1, 9'd1, 1'b0, 1'b0},
      '{1'b0, 64'h5555_5555_5555_5555, 4'd10, 1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd5,  1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'h5555_5555_5555_5555, 4'd10, 1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd10, 1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd5,  1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'h0,                   4'd3,  1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b1, 64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, 9'd0, 1'b0, 1'b0},
      '{1'b0, 64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, 9'd0, 1'b0, 1'b0}
    };
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumRows; i++) begin
      row = directed_rows[i];
      r   = '{row.clear, row.key, row.rn};
      w   = '{row.total, row.rep, row.full};
      send_txn(r, row.typed, w);
    end
    while (items_sent < RandomItems + NumRows) begin
      if (!full_done && items_sent >= 300) begin
        run_full_set();
        full_done = 1'b1;
      end else begin
        run_small_set();
      end
    end
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TblDepth + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS pulse_return_conflict_counter_top");
    end else begin
      $display("FAIL pulse_return_conflict_counter_top");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/prcc_pkg.sv
rtl/core/prcc_cell.sv
rtl/core/prcc_tally.sv
rtl/core/pulse_return_conflict_counter_top.sv
tb/pulse_return_conflict_counter_top_tb.sv
